// ===== hdl/itoa_pkg.sv =====
// Package for the integer-to-ASCII converter: word types, field widths and
// character constants. No dependencies.
`default_nettype none

package itoa_pkg;

  localparam int VALUE_W       = 32;
  localparam int RADIX_W       = 6;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 8;
  // quotient bits resolved per divider cycle; VALUE_W is a multiple of it
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'd45;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd87;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [RADIX_W-1:0] radix;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hdl/itoa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/itoa_div.sv =====
// Iterative divider of the running quotient by the radix, BITS_PER_STEP
// quotient bits per cycle. Depends on itoa_pkg.
`default_nettype none

module itoa_div
  import itoa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [VALUE_W-1:0] dividend,
  input  wire logic [RADIX_W-1:0] divisor,
  output div_res_t                res
);

  localparam int STEP_CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [STEP_CW-1:0] step_r, step_nxt;
  logic [VALUE_W-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] dv_r, dv_nxt;

  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] rem_v;
    logic [VALUE_W-1:0] q_v;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    rem_v    = rem_r;
    q_v      = q_r;
    trial    = '0;
    if (go) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
    end else if (run_r) begin
      // shift dividend bits out at the top, quotient bits in at the bottom
      for (int i = 0; i < BITS_PER_STEP; i++) begin
        trial = {rem_v, q_v[VALUE_W-1]};
        q_v   = {q_v[VALUE_W-2:0], 1'b0};
        if (trial >= {1'b0, dv_r}) begin
          trial  = trial - {1'b0, dv_r};
          q_v[0] = 1'b1;
        end
        rem_v = trial[DIGIT_W-1:0];
      end
      q_nxt    = q_v;
      rem_nxt  = rem_v;
      step_nxt = step_r + STEP_CW'(1);
      if (step_r == STEP_CW'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = q_r;
  assign res.remainder = rem_r;

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_radix.sv =====
// Top level of the integer-to-ASCII converter: sequencer, digit store and
// output register. Depends on itoa_pkg, itoa_div and itoa_ram.
`default_nettype none

// Channel   Ports                  Handshake
// input     start, busy, in_word   taken when start is high and busy is low
// result    out_strobe, out_word   one word per strobe cycle, cannot stall
//
// Each digit costs a divider launch, the divide steps and a store into the
// digit store; the digits are then read back, most significant first.
// Reset clears the sequencer, divider control and out_strobe only; the digit
// store needs no clearing because every entry read was written earlier for
// the same number. The last character is on the ports in the first cycle
// after busy falls.
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_strobe,
  output out_word_t     out_word
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] quot_r, quot_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic               minus_r, minus_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               div_go_r, div_go_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_word_t          out_word_r, out_word_nxt;

  div_res_t           div_res;
  logic               ram_we;
  logic               ram_re;
  logic [CNT_W-1:0]   rd_prev;
  logic [DIGIT_W-1:0] ram_rdata;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    return (d > DIGIT_MAX_DEC) ? (dw + LETTER_OFFSET) : (dw + CHAR_ZERO);
  endfunction

  itoa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (quot_r),
    .divisor  (radix_r),
    .res      (div_res)
  );

  assign ram_we  = (state_r == S_DIV) && div_res.done;
  assign ram_re  = (state_r == S_OUT) && (rd_idx_r != '0);
  assign rd_prev = rd_idx_r - CNT_W'(1);

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (div_res.remainder),
    .re    (ram_re),
    .raddr (rd_prev[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic [RADIX_W-1:0] r_v;
    logic               neg_v;
    state_nxt      = state_r;
    quot_nxt       = quot_r;
    radix_nxt      = radix_r;
    minus_nxt      = minus_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = 1'b0;
    div_go_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    r_v            = in_word.radix;
    neg_v          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (in_word.radix < RADIX_MIN) begin
            r_v = RADIX_MIN;
          end else if (in_word.radix > RADIX_MAX) begin
            r_v = RADIX_MAX;
          end
          neg_v      = (r_v == RADIX_DEC) && in_word.value[VALUE_W-1];
          radix_nxt  = r_v;
          minus_nxt  = neg_v;
          // most negative value wraps to its unsigned magnitude
          quot_nxt   = neg_v ? (~in_word.value + VALUE_W'(1)) : in_word.value;
          cnt_nxt    = '0;
          div_go_nxt = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          quot_nxt = div_res.quotient;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if ((div_res.quotient == '0) || (cnt_r + CNT_W'(1) == CNT_W'(MAX_DIGITS))) begin
            // drop the sign when the store is full
            minus_nxt  = minus_r && (cnt_r + CNT_W'(1) != CNT_W'(MAX_DIGITS));
            rd_idx_nxt = cnt_r + CNT_W'(1);
            state_nxt  = S_OUT;
          end else begin
            div_go_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (rd_idx_r != '0) begin
          rd_idx_nxt = rd_prev;
          pend_nxt   = 1'b1;
        end
        // sign goes out while the first digit read is in flight
        if (minus_r) begin
          minus_nxt             = 1'b0;
          out_strobe_nxt        = 1'b1;
          out_word_nxt.char_out = CHAR_MINUS;
          out_word_nxt.last     = 1'b0;
        end else if (pend_r) begin
          out_strobe_nxt        = 1'b1;
          out_word_nxt.char_out = digit_char(ram_rdata);
          out_word_nxt.last     = (rd_idx_r == '0);
          if (rd_idx_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      minus_r      <= 1'b0;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      div_go_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      quot_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      minus_r      <= minus_nxt;
      cnt_r        <= cnt_nxt;
      rd_idx_r     <= rd_idx_nxt;
      pend_r       <= pend_nxt;
      div_go_r     <= div_go_nxt;
      out_strobe_r <= out_strobe_nxt;
      quot_r       <= quot_nxt;
    end
    radix_r    <= radix_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

// ===== test/integer_to_ascii_radix_checker.sv =====
// Checker for integer_to_ascii_radix: predicts the character stream of every
// accepted number and compares it with the result strobes. Depends on itoa_pkg.
module integer_to_ascii_radix_checker
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_strobe,
  input  out_word_t out_word,
  output int        error_count,
  output int        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS = 32;
  localparam int REPORT_LIMIT = 10;

  out_word_t expected_chars[$];

  // Build the text of one number, most significant character first.
  function automatic void spell_number(in_word_t w);
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] digits[$];
    logic [DIGIT_W-1:0] d;
    out_word_t ch;
    bit negative;
    base = w.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    else if (base > RADIX_MAX) base = RADIX_MAX;
    negative = (base == RADIX_DEC) && w.value[VALUE_W-1];
    mag = w.value;
    if (negative) mag = ~mag + 1'b1;
    // zero still yields one digit; past the store size, high digits drop
    do begin
      digits.push_front(DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != 0 && digits.size() < MAX_DIGITS);
    if (negative && digits.size() < MAX_DIGITS) begin
      ch.char_out = CHAR_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      d = digits[i];
      ch.char_out = (d > DIGIT_MAX_DEC) ? LETTER_OFFSET + d : CHAR_ZERO + d;
      ch.last = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void flag_error(string what, out_word_t want, out_word_t got);
    if (error_count < REPORT_LIMIT)
      $display("%0t: %s: expected char %h last %b, got char %h last %b", $realtime, what,
               want.char_out, want.last, got.char_out, got.last);
    error_count++;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      // compare first: a strobe on this edge belongs to an older number
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          want = '0;
          flag_error("unexpected word", want, out_word);
        end else begin
          want = expected_chars.pop_front();
          if (out_word.char_out !== want.char_out || out_word.last !== want.last)
            flag_error("word mismatch", want, out_word);
        end
      end
      if (start && !busy) spell_number(in_word);
    end
    words_pending = expected_chars.size();
  end

endmodule

// ===== test/integer_to_ascii_radix_tb.sv =====
// Testbench top for integer_to_ascii_radix: clock, reset, directed and random
// numbers, and the verdict. Depends on itoa_pkg, integer_to_ascii_radix and its checker.
module integer_to_ascii_radix_tb
  import itoa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 237;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;
  int        error_count;
  int        words_pending;
  int        cycle_count = 0;
  int        items_sent = 0;

  integer_to_ascii_radix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  integer_to_ascii_radix_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_word      (in_word),
    .out_strobe   (out_strobe),
    .out_word     (out_word),
    .error_count  (error_count),
    .words_pending(words_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_to_ascii_radix verification failed");
      $finish;
    end
  end

  // Hold the word with start high until the block takes it.
  task automatic send_number(input logic signed [VALUE_W-1:0] v,
                             input logic [RADIX_W-1:0] r);
    // no idling over a long middle stretch
    if ((items_sent < 120 || items_sent >= 190) && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 150)) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= '{value: v, radix: r};
    while (busy) @(negedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: v = -($urandom >> $urandom_range(31));
      default: v = $urandom_range(40) - 20;
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return RADIX_DEC;
    if (pick < 30) return RADIX_W'($urandom_range(1));
    if (pick < 38) return RADIX_W'($urandom_range(37, 63));
    return RADIX_W'($urandom_range(2, 36));
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_number(0, RADIX_DEC);
    send_number(0, 6'd2);
    send_number(1, 6'd2);
    send_number(32'sh7fff_ffff, RADIX_DEC);
    send_number(32'sh8000_0000, RADIX_DEC);
    send_number(-1, RADIX_DEC);
    send_number(-1, 6'd2);
    send_number(-1, 6'd16);
    send_number(32'sh8000_0000, 6'd16);
    send_number(32'sh7fff_ffff, 6'd8);
    send_number(35, RADIX_MAX);
    send_number(36, RADIX_MAX);
    send_number(-1, RADIX_MAX);
    send_number(255, 6'd16);
    send_number(123456789, RADIX_DEC);
    send_number(-42, RADIX_DEC);
    send_number(9, RADIX_DEC);
    send_number(-5, 6'd7);
    // out-of-range radixes fold to binary or base 36
    send_number(10, 6'd0);
    send_number(10, 6'd1);
    send_number(71, 6'd37);
    send_number(-1000, 6'd63);
    send_number(32'sh5555_aaaa, 6'd42);

    repeat (RANDOM_ITEMS) send_number(random_value(), random_radix());
    start <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && words_pending == 0) begin
      $display("integer_to_ascii_radix verification clean");
    end else begin
      $display("integer_to_ascii_radix verification failed");
    end
    $finish;
  end

endmodule
